@@ sv/ubs_pkg.sv @@
// ubs_pkg: shared types and constants for the bounded undo stack
// holds the operation codes, controller states and the control/status structs
// no dependencies
package ubs_pkg;

  localparam int KEY_W      = 64;
  localparam int PORT_FLD_W = 16;
  localparam int OCC_W      = 5;
  localparam int CAP_W      = 5;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PURGE = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PURGE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic clear;
    logic purge_start;
    logic purge_step;
    logic purge_end;
    logic finish;
  } ubs_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  slot_free;
    logic  purge_done;
  } ubs_stat_t;

endpackage

@@ sv/bounded_undo_stack_with_purge_unit.sv @@
// bounded_undo_stack_with_purge_unit: top level of the bounded undo stack
// push, pop and clear pass from the item register through the exec and finish states to the
// result register; a purge adds a walk state that reads one record per cycle through the
// single read port of the record store and compacts the kept records in place
// a new item is taken only once the last one has reached the result register; finish waits for a free result slot
// reset (rst, synchronous): stack empty, capacity 16, no result pending
module bounded_undo_stack_with_purge_unit #(
  parameter int DEPTH       = 16,
  parameter int FOLDER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // capacity register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ubs_pkg::CAP_W-1:0]         cfg_data,
  // incoming item
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // msg_key [63:0], src_folder [79:64], dst_folder [95:80]
  input  logic [ubs_pkg::IN_DATA_W-1:0]     s_tdata,
  // kind [1:0]
  input  logic [1:0]                        s_tuser,
  // result item
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // ok [0], out_key [64:1], out_src [80:65], out_dst [96:81],
  // occupancy [101:97], zero pad [103:102]
  output logic [ubs_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import ubs_pkg::*;

  ubs_cmd_t  cmd;
  ubs_stat_t stat;

  logic                  out_ok;
  logic [KEY_W-1:0]      out_key;
  logic [PORT_FLD_W-1:0] out_src;
  logic [PORT_FLD_W-1:0] out_dst;
  logic [OCC_W-1:0]      out_occ;

  // the user must write the register only while the block is idle; the block does not enforce it, so always take it
  assign cfg_ready = 1'b1;

  // controller: one item at a time, steps through exec, purge walk and finish
  ubs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: records live in a ring (head = oldest), so dropping the
  // oldest is a head bump; purge compacts in place, read ahead of write
  ubs_dp #(
    .DEPTH       (DEPTH),
    .FOLDER_BITS (FOLDER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_kind   (kind_t'(s_tuser)),
    .in_key    (s_tdata[63:0]),
    .in_src    (s_tdata[79:64]),
    .in_dst    (s_tdata[95:80]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ok    (out_ok),
    .out_key   (out_key),
    .out_src   (out_src),
    .out_dst   (out_dst),
    .out_occ   (out_occ)
  );

  // result packing, lowest field first
  assign m_tdata = {2'b00, out_occ, out_dst, out_src, out_key, out_ok};

endmodule

@@ sv/ubs_ctrl.sv @@
// ubs_ctrl: sequencing state machine of the undo stack
// issues commands to ubs_dp and reads its status; depends on ubs_pkg
module ubs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ubs_pkg::ubs_stat_t  stat,
  output ubs_pkg::ubs_cmd_t   cmd
);
  import ubs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.kind)
          KIND_PUSH: begin
            cmd.push   = 1'b1;
            state_next = ST_FINISH;
          end
          KIND_POP: begin
            cmd.pop    = 1'b1;
            state_next = ST_FINISH;
          end
          KIND_PURGE: begin
            cmd.purge_start = 1'b1;
            state_next      = ST_PURGE;
          end
          default: begin
            cmd.clear  = 1'b1;
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_PURGE: begin
        if (stat.purge_done) begin
          cmd.purge_end = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.purge_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ubs_dp.sv @@
// ubs_dp: record storage, ring pointers, purge compaction and result register
// driven by ubs_ctrl commands; depends on ubs_pkg
module ubs_dp #(
  parameter int DEPTH       = 16,
  parameter int FOLDER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [ubs_pkg::CAP_W-1:0]           cfg_data,
  input  ubs_pkg::kind_t                      in_kind,
  input  logic [ubs_pkg::KEY_W-1:0]           in_key,
  input  logic [ubs_pkg::PORT_FLD_W-1:0]      in_src,
  input  logic [ubs_pkg::PORT_FLD_W-1:0]      in_dst,
  input  ubs_pkg::ubs_cmd_t                   cmd,
  output ubs_pkg::ubs_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic [ubs_pkg::KEY_W-1:0]           out_key,
  output logic [ubs_pkg::PORT_FLD_W-1:0]      out_src,
  output logic [ubs_pkg::PORT_FLD_W-1:0]      out_dst,
  output logic [ubs_pkg::OCC_W-1:0]           out_occ
);
  import ubs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = CW + 1;
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  // record storage
  logic [KEY_W-1:0]       key_mem [DEPTH];
  logic [FOLDER_BITS-1:0] src_mem [DEPTH];
  logic [FOLDER_BITS-1:0] dst_mem [DEPTH];

  logic [CAP_W-1:0]       capacity;
  kind_t                  item_kind;
  logic [KEY_W-1:0]       item_key;
  logic [FOLDER_BITS-1:0] item_src;
  logic [FOLDER_BITS-1:0] item_dst;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] wr_ptr;
  logic          pvalid;
  logic          pop_hit;

  logic [KEY_W-1:0]       rd_key;
  logic [FOLDER_BITS-1:0] rd_src;
  logic [FOLDER_BITS-1:0] rd_dst;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [KEY_W-1:0]       wkey;
  logic [FOLDER_BITS-1:0] wsrc;
  logic [FOLDER_BITS-1:0] wdst;
  logic                   re;
  logic [AW-1:0]          raddr;

  logic [XW-1:0] cap_x;
  logic [XW-1:0] cap_c;
  logic [CW-1:0] cap_live;
  logic [CW-1:0] drop;
  logic          keep;
  logic          rd_more;

  // capacity clamped into 1..DEPTH
  always_comb begin
    cap_x = XW'(capacity);
    if (cap_x == '0) begin
      cap_c = XW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_c = XW'(DEPTH);
    end else begin
      cap_c = cap_x;
    end
    cap_live = cap_c[CW-1:0];
    drop     = (count >= cap_live) ? count - cap_live + CW'(1) : '0;
  end

  assign keep    = (rd_src != item_src) && (rd_dst != item_src);
  assign rd_more = (rd_ptr != count);

  always_comb begin
    we    = 1'b0;
    waddr = wrap(SW'(head) + SW'(count));
    wkey  = item_key;
    wsrc  = item_src;
    wdst  = item_dst;
    re    = 1'b0;
    raddr = wrap(SW'(head) + SW'(count) - SW'(1));
    if (cmd.push) begin
      we = 1'b1;
    end
    if (cmd.pop && count != '0) begin
      re = 1'b1;
    end
    if (cmd.purge_step) begin
      re    = rd_more;
      raddr = wrap(SW'(head) + SW'(rd_ptr));
      we    = pvalid && keep;
      waddr = wrap(SW'(head) + SW'(wr_ptr));
      wkey  = rd_key;
      wsrc  = rd_src;
      wdst  = rd_dst;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      src_mem[waddr] <= wsrc;
      dst_mem[waddr] <= wdst;
    end
    if (re) begin
      rd_key <= key_mem[raddr];
      rd_src <= src_mem[raddr];
      rd_dst <= dst_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= in_kind;
      item_key  <= in_key;
      item_src  <= FOLDER_BITS'(in_src);
      item_dst  <= FOLDER_BITS'(in_dst);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      count    <= '0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      pvalid   <= 1'b0;
      pop_hit  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (cmd.load) begin
        pop_hit <= 1'b0;
      end
      if (cmd.push) begin
        head  <= wrap(SW'(head) + SW'(drop));
        count <= count - drop + CW'(1);
      end
      if (cmd.pop && count != '0) begin
        count   <= count - CW'(1);
        pop_hit <= 1'b1;
      end
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.purge_start) begin
        rd_ptr <= '0;
        wr_ptr <= '0;
        pvalid <= 1'b0;
      end
      if (cmd.purge_step) begin
        pvalid <= rd_more;
        if (rd_more) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (pvalid && keep) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
      end
      if (cmd.purge_end) begin
        count <= wr_ptr;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ok  <= (item_kind != KIND_POP) || pop_hit;
      out_key <= pop_hit ? rd_key : '0;
      out_src <= pop_hit ? PORT_FLD_W'(rd_src) : '0;
      out_dst <= pop_hit ? PORT_FLD_W'(rd_dst) : '0;
      out_occ <= OCC_W'(count);
    end
  end

  assign stat.kind       = item_kind;
  assign stat.slot_free  = !out_valid || out_ready;
  assign stat.purge_done = !rd_more && !pvalid;

endmodule

@@ tb/bounded_undo_stack_with_purge_unit_tb.sv @@
// bounded_undo_stack_with_purge_unit_tb: self-checking testbench for the bounded undo stack
// drives push, pop, purge and clear items with random gaps and checks each result
// against a cycle-free model of the stack; depends on ubs_pkg and the top level rtl
module bounded_undo_stack_with_purge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ubs_pkg::*;

  localparam int DEPTH = 16;

  // one expected result item, fields at the block's widths
  typedef struct {
    logic                  ok;
    logic [KEY_W-1:0]      key;
    logic [PORT_FLD_W-1:0] src;
    logic [PORT_FLD_W-1:0] dst;
    logic [OCC_W-1:0]      occ;
  } stack_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // block ports, all inputs known from time zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  bounded_undo_stack_with_purge_unit #(
    .DEPTH      (DEPTH),
    .FOLDER_BITS(16)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predicted stack contents, entry 0 is the oldest record
  logic [KEY_W-1:0]      rec_key [DEPTH];
  logic [PORT_FLD_W-1:0] rec_src [DEPTH];
  logic [PORT_FLD_W-1:0] rec_dst [DEPTH];
  int unsigned           rec_count   = 0;
  logic [CAP_W-1:0]      cap_setting = CAP_RESET;

  // results still owed by the block, oldest first
  stack_result_t pending_results[$];
  int            errors = 0;

  // shared knobs for the idling processes
  bit no_idle     = 1'b0;  // both sides run without gaps
  int hold_cycles = 0;     // long receiver hold-off, taken after the next result

  // model of one operation: updates the predicted stack and returns its result
  function automatic stack_result_t apply_op(kind_t k, logic [KEY_W-1:0] key,
                                             logic [PORT_FLD_W-1:0] src,
                                             logic [PORT_FLD_W-1:0] dst);
    stack_result_t r;
    int unsigned   lim;
    int unsigned   wr;
    r.ok  = 1'b1;
    r.key = '0;
    r.src = '0;
    r.dst = '0;
    case (k)
      KIND_PUSH: begin
        // zero capacity acts as one, anything above the depth acts as the depth
        if (cap_setting == 0) lim = 1;
        else if (cap_setting > DEPTH) lim = DEPTH;
        else lim = cap_setting;
        // drop oldest records until a slot is free, also after a lowered capacity
        while (rec_count >= lim) begin
          for (int i = 1; i < rec_count; i++) begin
            rec_key[i-1] = rec_key[i];
            rec_src[i-1] = rec_src[i];
            rec_dst[i-1] = rec_dst[i];
          end
          rec_count--;
        end
        rec_key[rec_count] = key;
        rec_src[rec_count] = src;
        rec_dst[rec_count] = dst;
        rec_count++;
      end
      KIND_POP: begin
        // pop on an empty stack fails and leaves everything as it was
        if (rec_count == 0) begin
          r.ok = 1'b0;
        end else begin
          rec_count--;
          r.key = rec_key[rec_count];
          r.src = rec_src[rec_count];
          r.dst = rec_dst[rec_count];
        end
      end
      KIND_PURGE: begin
        // keep records touching neither side of the folder, order preserved
        wr = 0;
        for (int rd = 0; rd < rec_count; rd++) begin
          if (rec_src[rd] != src && rec_dst[rd] != src) begin
            rec_key[wr] = rec_key[rd];
            rec_src[wr] = rec_src[rd];
            rec_dst[wr] = rec_dst[rd];
            wr++;
          end
        end
        rec_count = wr;
      end
      default: begin
        rec_count = 0;
      end
    endcase
    r.occ = rec_count[OCC_W-1:0];
    return r;
  endfunction

  // offer one item after a random gap and predict its result once it is taken;
  // valid is left high so a back-to-back item needs no second assignment
  task automatic send_item(kind_t k, logic [KEY_W-1:0] key,
                           logic [PORT_FLD_W-1:0] src, logic [PORT_FLD_W-1:0] dst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {dst, src, key};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_op(k, key, src, dst));
  endtask

  // stop offering and wait until every owed result has been taken,
  // then give a purge-length margin so the block is surely idle
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  // capacity write, only issued while the block is idle
  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cap_setting = value;
    @(posedge clk);
  endtask

  // folder ids mostly from a small pool so purges hit, sometimes anything
  function automatic logic [PORT_FLD_W-1:0] pick_folder();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return PORT_FLD_W'($urandom_range(0, 5));
    if (r == 6) return '1;
    return PORT_FLD_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // one random item, weighted toward pushes so the stack fills up
  task automatic send_random_item();
    int    r;
    kind_t k;
    r = $urandom_range(0, 99);
    if (r < 50) k = KIND_PUSH;
    else if (r < 75) k = KIND_POP;
    else if (r < 93) k = KIND_PURGE;
    else k = KIND_CLEAR;
    send_item(k, rand_key(), pick_folder(), pick_folder());
  endtask

  // per-field comparison with a report on mismatch
  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker: each taken result against the oldest prediction
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none actual %0h",
                 $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok",        want.ok,  m_tdata[0]);
        check_field("out_key",   want.key, m_tdata[64:1]);
        check_field("out_src",   want.src, m_tdata[80:65]);
        check_field("out_dst",   want.dst, m_tdata[96:81]);
        check_field("occupancy", want.occ, m_tdata[101:97]);
      end
    end
  end

  // receiver: random stall per result item, plus an optional long hold-off
  initial begin
    int wait_n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      wait_n = no_idle ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // empty-stack behavior right after reset: failed pop, purge and clear
  task automatic test_empty_stack();
    send_item(KIND_POP,   '1, '1, '1);
    send_item(KIND_PURGE, '0, '0, '1);
    send_item(KIND_CLEAR, '1, '0, '0);
    wait_all_results();
  endtask

  // field extremes through a push and pop round trip
  task automatic test_field_extremes();
    send_item(KIND_PUSH, '1, '1, '0);
    send_item(KIND_PUSH, '0, '0, '1);
    send_item(KIND_POP,  64'h5555_aaaa_5555_aaaa, 16'h5555, 16'haaaa);
    send_item(KIND_POP,  64'haaaa_5555_aaaa_5555, 16'haaaa, 16'h5555);
    wait_all_results();
  endtask

  // zero capacity keeps only one record
  task automatic test_zero_capacity();
    write_capacity(5'd0);
    send_item(KIND_PUSH, 64'h0123_4567_89ab_cdef, 16'h0001, 16'h0002);
    send_item(KIND_PUSH, 64'hfedc_ba98_7654_3210, 16'h0003, 16'h0004);
    send_item(KIND_POP,  '0, '0, '0);
    send_item(KIND_POP,  '0, '0, '0);
    wait_all_results();
  endtask

  // capacity lowered below the held count trims only on the next push
  task automatic test_capacity_lowered();
    write_capacity(CAP_RESET);
    send_item(KIND_PUSH, 64'h11, 16'h0010, 16'h0020);
    send_item(KIND_PUSH, 64'h22, 16'h0011, 16'h0021);
    send_item(KIND_PUSH, 64'h33, 16'h0012, 16'h0022);
    wait_all_results();
    write_capacity(5'd2);
    send_item(KIND_PUSH, 64'h44, 16'h0013, 16'h0023);
    send_item(KIND_POP,  '0, '0, '0);
    send_item(KIND_POP,  '0, '0, '0);
    wait_all_results();
  endtask

  // purge matching on source in one record and destination in another
  task automatic test_purge_match();
    write_capacity(CAP_RESET);
    send_item(KIND_PUSH,  64'haa, 16'h0005, 16'h0001);
    send_item(KIND_PUSH,  64'hbb, 16'h0002, 16'h0005);
    send_item(KIND_PUSH,  64'hcc, 16'h0003, 16'h0004);
    send_item(KIND_PURGE, '0,     16'h0005, 16'hffff);
    send_item(KIND_POP,   '0, '0, '0);
    send_item(KIND_POP,   '0, '0, '0);
    wait_all_results();
  endtask

  // random phases across capacity settings, extremes and out-of-range values included;
  // the state carries over between phases so lowered capacities get exercised
  task automatic test_random_phases();
    logic [CAP_W-1:0] caps[] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd9,
                                 5'd5};
    foreach (caps[p]) begin
      wait_all_results();
      write_capacity(p == caps.size() - 1 ? CAP_W'($urandom_range(0, 31)) : caps[p]);
      // one phase without any idling on either side
      no_idle = (p == 7);
      for (int n = 0; n < 80; n++) begin
        send_random_item();
        // now and then the sender pauses until nothing is owed
        if ($urandom_range(0, 49) == 0) wait_all_results();
      end
      no_idle = 1'b0;
    end
    wait_all_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    write_capacity(CAP_RESET);
    hold_cycles = 200;
    no_idle     = 1'b1;
    for (int n = 0; n < 40; n++) send_random_item();
    no_idle = 1'b0;
    wait_all_results();
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_stack();
    test_field_extremes();
    test_zero_capacity();
    test_capacity_lowered();
    test_purge_match();
    test_output_backpressure();
    test_random_phases();
    if (pending_results.size() != 0) begin
      $display("%0t ns: results left over, expected 0 actual %0d", $time,
               pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ bounded_undo_stack_with_purge_unit.f @@
sv/ubs_pkg.sv
sv/ubs_ctrl.sv
sv/ubs_dp.sv
sv/bounded_undo_stack_with_purge_unit.sv
tb/bounded_undo_stack_with_purge_unit_tb.sv
